@@ rtl/pbd_pkg.sv @@
`timescale 1ns / 1ps

package pbd_pkg;

  // Sample and arithmetic sizing.
  localparam int SAMPLE_W     = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD_BITS   = 8;
  localparam int TABLE_LEN    = 24;
  localparam int NUM_STEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int STEP_W       = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
  localparam int TAB_IDX_W    = $clog2(TABLE_LEN);

  // The rotated vector grows by the CORDIC gain (under 1.65) times sqrt(2).
  localparam int XY_W = SAMPLE_W + 1 + GUARD_BITS + 3;

  // Angle is a 32-bit fraction of a full turn.
  localparam int ANGLE_W = 32;
  localparam logic [ANGLE_W-1:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] HALF_SECTOR = 32'h0080_0000;

  // Group and position counters.
  localparam int MODE_W = 8;
  localparam int MPB_W  = 9;
  localparam logic [MPB_W-1:0] MPB_MAX   = 9'd256;
  localparam logic [MPB_W-1:0] MPB_RESET = 9'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              step;
    logic [STEP_W-1:0] step_idx;
    logic              deliver;
    logic              byte_valid;
    logic              final_result;
    logic              length_error;
    logic [MODE_W-1:0] byte_pos;
  } pbd_cmd_t;

  // Arctangent of 2^-i as a fraction of a turn, scaled by 2^32.
  function automatic logic [ANGLE_W-1:0] atan_turn(input logic [TAB_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2F9;
      5'd15:   v = 32'h0000_517C;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A2F;
      5'd19:   v = 32'h0000_0517;
      5'd20:   v = 32'h0000_028B;
      5'd21:   v = 32'h0000_0145;
      5'd22:   v = 32'h0000_00A2;
      5'd23:   v = 32'h0000_0051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/pbd_if.sv @@
`timescale 1ns / 1ps

// Input vector channel.
interface pbd_in_if;
  import pbd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] cos_part;
  logic signed [SAMPLE_W-1:0] sin_part;
  logic                       end_of_text;
  modport source (output valid, cos_part, sin_part, end_of_text, input ready);
  modport sink   (input valid, cos_part, sin_part, end_of_text, output ready);
endinterface

// Decoded result channel.
interface pbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_valid;
  logic       final_result;
  logic       length_error;
  modport source (output valid, byte_value, byte_valid, final_result, length_error,
                  input ready);
  modport sink   (input valid, byte_value, byte_valid, final_result, length_error,
                  output ready);
endinterface

// Configuration write channel for modes_per_byte.
interface pbd_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/phase_to_byte_decoder.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Payload
// in_ch     in   valid / ready    cos_part[15:0], sin_part[15:0], end_of_text
// out_ch    out  valid / ready    byte_value[7:0], byte_valid, final_result, length_error
// cfg_ch    in   valid / ready    data[8:0] = modes_per_byte
//
// A vector that opens a group is accepted, runs 16 CORDIC iterations of the
// shared shift-add unit, then passes to delivery into the output register.
// An end-of-text vector inside a group goes straight to delivery with no rotation.
// Reset is synchronous and active low; modes_per_byte returns to 1 and both counters
// to 0. A stalled result holds in the output register; a finished rotation waits in the
// delivery state until that register frees, and the input stalls meanwhile.

module phase_to_byte_decoder (
  input logic       clk,
  input logic       rst_n,
  pbd_in_if.sink    in_ch,
  pbd_out_if.source out_ch,
  pbd_cfg_if.sink   cfg_ch
);
  import pbd_pkg::*;

  pbd_cmd_t cmd;

  // Sequencer for groups, positions and the rotation loop.
  pbd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .end_of_text (in_ch.end_of_text),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_data    (cfg_ch.data),
    .cmd         (cmd)
  );

  // CORDIC vectoring unit, sector rounding and the output register.
  pbd_datapath u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .cos_part     (in_ch.cos_part),
    .sin_part     (in_ch.sin_part),
    .byte_value   (out_ch.byte_value),
    .byte_valid   (out_ch.byte_valid),
    .final_result (out_ch.final_result),
    .length_error (out_ch.length_error)
  );

endmodule

@@ rtl/pbd_datapath.sv @@
`timescale 1ns / 1ps

module pbd_datapath (
  input  logic                                clk,
  input  pbd_pkg::pbd_cmd_t                   cmd,
  input  logic signed [pbd_pkg::SAMPLE_W-1:0] cos_part,
  input  logic signed [pbd_pkg::SAMPLE_W-1:0] sin_part,
  output logic [7:0]                          byte_value,
  output logic                                byte_valid,
  output logic                                final_result,
  output logic                                length_error
);
  import pbd_pkg::*;

  logic signed [XY_W-1:0]    x_r, y_r;
  logic [ANGLE_W-1:0]        z_r;
  logic                      zero_r;
  logic                      bvalid_r, final_r, err_r;
  logic [MODE_W-1:0]         pos_r;
  logic [7:0]                out_byte_r;
  logic                      out_bvalid_r, out_final_r, out_err_r;

  logic signed [SAMPLE_W:0]  cos_ext, sin_ext;
  logic signed [XY_W-1:0]    x_ld, y_ld, xs, ys;
  logic [ANGLE_W-1:0]        z_ld, atan_v, z_rnd;
  logic [7:0]                sector;

  // Fold the left half plane onto the right one and add guard bits.
  always_comb begin
    cos_ext = {cos_part[SAMPLE_W-1], cos_part};
    sin_ext = {sin_part[SAMPLE_W-1], sin_part};
    if (cos_part < 0) begin
      x_ld = XY_W'(-cos_ext) <<< GUARD_BITS;
      y_ld = XY_W'(-sin_ext) <<< GUARD_BITS;
      z_ld = HALF_TURN;
    end else begin
      x_ld = XY_W'(cos_ext) <<< GUARD_BITS;
      y_ld = XY_W'(sin_ext) <<< GUARD_BITS;
      z_ld = '0;
    end
  end

  // One CORDIC micro-rotation; the shifts floor toward minus infinity.
  assign xs     = x_r >>> cmd.step_idx;
  assign ys     = y_r >>> cmd.step_idx;
  assign atan_v = atan_turn(TAB_IDX_W'(cmd.step_idx));

  // Round to the nearest of 256 sectors; a zero vector reads as angle 0.
  assign z_rnd  = (zero_r ? '0 : z_r) + HALF_SECTOR;
  assign sector = z_rnd[ANGLE_W-1 -: 8];

  // Rotation registers and the result metadata of the current beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= x_ld;
      y_r      <= y_ld;
      z_r      <= z_ld;
      zero_r   <= (cos_part == '0) && (sin_part == '0);
      bvalid_r <= cmd.byte_valid;
      final_r  <= cmd.final_result;
      err_r    <= cmd.length_error;
      pos_r    <= cmd.byte_pos;
    end else if (cmd.step) begin
      if (!y_r[XY_W-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_v;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_v;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_byte_r   <= bvalid_r ? (sector - pos_r) : 8'd0;
      out_bvalid_r <= bvalid_r;
      out_final_r  <= final_r;
      out_err_r    <= err_r;
    end
  end

  assign byte_value   = out_byte_r;
  assign byte_valid   = out_bvalid_r;
  assign final_result = out_final_r;
  assign length_error = out_err_r;

endmodule

@@ rtl/pbd_ctrl.sv @@
`timescale 1ns / 1ps

module pbd_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     end_of_text,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [pbd_pkg::MPB_W-1:0] cfg_data,
  output pbd_pkg::pbd_cmd_t        cmd
);
  import pbd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ROTATE, S_DELIVER} state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [MODE_W-1:0]   pos_r, pos_nxt;
  logic [MPB_W-1:0]    mpb_r, mpb_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                in_fire, decode, deliver, last_step;
  logic [MPB_W-1:0]    mpb_eff, mode_inc;
  logic [MODE_W-1:0]   mode_adv;
  logic                err;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign last_step = (step_r == STEP_W'(NUM_STEPS - 1));
  assign deliver   = (state_r == S_DELIVER) && (!out_valid_r || out_ready);

  // Group bookkeeping: clamp the register and advance the mode counter.
  always_comb begin
    if (mpb_r == '0) begin
      mpb_eff = MPB_RESET;
    end else if (mpb_r > MPB_MAX) begin
      mpb_eff = MPB_MAX;
    end else begin
      mpb_eff = mpb_r;
    end
    decode   = (mode_r == '0);
    mode_inc = MPB_W'(mode_r) + MPB_W'(1);
    mode_adv = (mode_inc >= mpb_eff) ? '0 : mode_inc[MODE_W-1:0];
    err      = end_of_text && (mode_adv != '0);
  end

  // Next state and counters.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    mpb_nxt       = mpb_r;
    out_valid_nxt = out_valid_r;

    if (cfg_valid) begin
      mpb_nxt = cfg_data;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (end_of_text) begin
            mode_nxt = '0;
            pos_nxt  = '0;
          end else begin
            mode_nxt = mode_adv;
            pos_nxt  = decode ? pos_r + MODE_W'(1) : pos_r;
          end
          if (decode) begin
            state_nxt = S_ROTATE;
          end else if (end_of_text) begin
            state_nxt = S_DELIVER;
          end
        end
      end
      S_ROTATE: begin
        if (last_step) begin
          step_nxt  = '0;
          state_nxt = S_DELIVER;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_DELIVER: begin
        if (deliver) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      mode_r      <= '0;
      pos_r       <= '0;
      mpb_r       <= MPB_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      mpb_r       <= mpb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd              = '0;
    cmd.load         = in_fire;
    cmd.step         = (state_r == S_ROTATE);
    cmd.step_idx     = step_r;
    cmd.deliver      = deliver;
    cmd.byte_valid   = decode;
    cmd.final_result = end_of_text;
    cmd.length_error = err;
    cmd.byte_pos     = pos_r;
  end

  // A decoded beat always starts the rotation loop.
  a_decode_rotates: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && decode |=> state_r == S_ROTATE)
    else $error("decoded beat did not enter rotation");

  // Results appear only out of the delivery state.
  a_valid_from_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DELIVER))
    else $error("result raised outside delivery");

  // End of text clears both counters.
  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && end_of_text |=> mode_r == '0 && pos_r == '0)
    else $error("counters not cleared after end of text");

  // The step counter rests at zero outside the rotation loop.
  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_ROTATE |-> step_r == '0)
    else $error("step counter not at rest");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    deliver |-> !out_valid_r || out_ready)
    else $error("result overwritten while pending");

endmodule
